@@ hdl/poi_pkg.sv @@
// shared constants, types and the cordic arctangent table for the odometry integrator
// no dependencies
package poi_pkg;

  localparam int unsigned MAX_STEP_US  = 1000000;
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned CORD_IW      = $clog2(CORDIC_STEPS);
  localparam int unsigned DT_W         = $clog2(MAX_STEP_US + 1);

  // cordic datapath, Q2.30 with headroom
  localparam int unsigned CW = 34;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

  // rounding division by a constant
  localparam int unsigned DIV_QB = 27;
  localparam int unsigned DIV_W  = 57;
  localparam logic [DIV_W-1:0] DEN_POS = 57'd1024000000;
  localparam logic [DIV_W-1:0] DEN_YAW = 57'd1000000;

  // both divisors are a power of two times 15625: shift first, then a reciprocal multiply
  localparam int unsigned DIV_NW     = 41;
  localparam int unsigned DIV_POS_SH = 16;
  localparam int unsigned DIV_YAW_SH = 6;
  localparam logic [DIV_NW-1:0] DIV_ODD   = 41'd15625;
  localparam logic [31:0]       DIV_RECIP = 32'd2251799813;  // floor(2^45 / 15625)

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_MOTION_ENABLE = 3'd0,
    REG_CMD_TIMEOUT   = 3'd1,
    REG_MOUNT_X       = 3'd2,
    REG_MOUNT_Y       = 3'd3,
    REG_MOUNT_Z       = 3'd4,
    REG_MOUNT_YAW     = 3'd5,
    REG_BASE_HEIGHT   = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic           start;
    logic           pos_den;
    logic [DIV_W-1:0] num;
  } div_req_t;

  function automatic logic signed [CW-1:0] atan_val(input logic [4:0] idx);
    logic signed [CW-1:0] v;
    unique case (idx)
      5'd0:  v = 34'sd536870912;
      5'd1:  v = 34'sd316933406;
      5'd2:  v = 34'sd167458907;
      5'd3:  v = 34'sd85004756;
      5'd4:  v = 34'sd42667331;
      5'd5:  v = 34'sd21354465;
      5'd6:  v = 34'sd10679838;
      5'd7:  v = 34'sd5340245;
      5'd8:  v = 34'sd2670163;
      5'd9:  v = 34'sd1335087;
      5'd10: v = 34'sd667544;
      5'd11: v = 34'sd333772;
      5'd12: v = 34'sd166886;
      5'd13: v = 34'sd83443;
      5'd14: v = 34'sd41722;
      5'd15: v = 34'sd20861;
      5'd16: v = 34'sd10430;
      5'd17: v = 34'sd5215;
      5'd18: v = 34'sd2608;
      5'd19: v = 34'sd1304;
      5'd20: v = 34'sd652;
      5'd21: v = 34'sd326;
      5'd22: v = 34'sd163;
      5'd23: v = 34'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ hdl/poi_cordic.sv @@
// iterative rotation-mode cordic, one micro-rotation per cycle
// depends on poi_pkg
module poi_cordic (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [31:0]                      phase_i,
  output logic                             done_o,
  output logic signed [poi_pkg::CW-1:0]    sin_o,
  output logic signed [poi_pkg::CW-1:0]    cos_o
);

  logic signed [poi_pkg::CW-1:0] x_q, y_q, a_q;
  logic [poi_pkg::CORD_IW-1:0]   i_q;
  logic                          run_q, flip_q, done_q;
  logic signed [poi_pkg::CW-1:0] a_in, xs, ys, at;

  always_comb begin
    a_in = poi_pkg::CW'($signed(phase_i));
    xs   = x_q >>> i_q;
    ys   = y_q >>> i_q;
    at   = poi_pkg::atan_val(5'(i_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
      flip_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        // fold the angle into the right half plane
        if (a_in > 34'sd1073741824) begin
          a_q    <= a_in - 34'sd2147483648;
          flip_q <= 1'b1;
        end else if (a_in < -34'sd1073741824) begin
          a_q    <= a_in + 34'sd2147483648;
          flip_q <= 1'b1;
        end else begin
          a_q    <= a_in;
          flip_q <= 1'b0;
        end
        x_q   <= poi_pkg::CORDIC_GAIN;
        y_q   <= '0;
        i_q   <= '0;
        run_q <= 1'b1;
      end else if (run_q) begin
        if (!a_q[poi_pkg::CW-1]) begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          a_q <= a_q - at;
        end else begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          a_q <= a_q + at;
        end
        i_q <= i_q + 1'b1;
        if (i_q == poi_pkg::CORD_IW'(poi_pkg::CORDIC_STEPS - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign cos_o  = flip_q ? -x_q : x_q;
  assign sin_o  = flip_q ? -y_q : y_q;

endmodule

@@ hdl/poi_div.sv @@
// division by the constant microsecond scale: shift, reciprocal multiply, one correction step
// depends on poi_pkg
module poi_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  poi_pkg::div_req_t           req_i,
  output logic                        done_o,
  output logic [poi_pkg::DIV_QB-1:0]  quo_o
);

  logic [poi_pkg::DIV_NW-1:0]  n_q, qm_q;
  logic [63:0]                 p_q;
  logic [poi_pkg::DIV_QB-1:0]  qe_q, quo_q;
  logic [2:0]                  ph_q;
  logic                        done_q;
  logic [poi_pkg::DIV_NW-1:0]  n_sh, rem;

  always_comb begin
    n_sh = req_i.pos_den ? poi_pkg::DIV_NW'(req_i.num >> poi_pkg::DIV_POS_SH)
                         : poi_pkg::DIV_NW'(req_i.num >> poi_pkg::DIV_YAW_SH);
    rem  = n_q - qm_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        n_q  <= n_sh;
        ph_q <= 3'b001;
      end else if (ph_q[0]) begin
        // estimate is the true quotient or one below it
        p_q  <= 64'(n_q[poi_pkg::DIV_NW-1:9]) * 64'(poi_pkg::DIV_RECIP);
        ph_q <= 3'b010;
      end else if (ph_q[1]) begin
        qe_q <= p_q[62:36];
        qm_q <= poi_pkg::DIV_NW'(p_q[62:36]) * poi_pkg::DIV_ODD;
        ph_q <= 3'b100;
      end else if (ph_q[2]) begin
        quo_q  <= (rem >= poi_pkg::DIV_ODD) ? qe_q + 1'b1 : qe_q;
        done_q <= 1'b1;
        ph_q   <= '0;
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

@@ hdl/planar_odometry_integrator.sv @@
// planar dead-reckoning integrator: sequencer, shared multiplier, config registers
// depends on poi_pkg, poi_cordic, poi_div
//
// channel  | direction | handshake            | payload
// in       | input     | in_valid/in_ready    | action, time_us, vel_fwd, vel_side, turn_rate
// out      | output    | out_valid/out_ready  | pos_x, pos_y, pos_z, quat_z, quat_w
// cfg      | input     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// a command transaction only updates the held command and its time; a tick result comes from
// three cordic passes with integration (two without), three divides with integration and
// the shared multiplier, each product registered in S_MUL and taken in S_ACC
// rst_ni clears pose, held command, flags and config to their reset values
// in_ready is low while a tick is in work; a stalled result blocks only the next tick's end
module planar_odometry_integrator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [31:0] time_us_i,
  input  logic signed [23:0] vel_fwd_i,
  input  logic signed [23:0] vel_side_i,
  input  logic signed [23:0] turn_rate_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o,
  output logic signed [15:0] quat_z_o,
  output logic signed [15:0] quat_w_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  typedef enum logic [2:0] {S_IDLE, S_CORD, S_MUL, S_ACC, S_DIV, S_OUT} state_e;
  typedef enum logic [1:0] {C_STEP, C_MOUNT, C_QUAT} cpass_e;
  typedef enum logic [3:0] {
    OP_FC, OP_SDS, OP_FS, OP_SDC, OP_VXDT, OP_VYDT, OP_TRDT,
    OP_MXC, OP_MYS, OP_MXS, OP_MYC
  } op_e;

  localparam int unsigned PW = 70;

  state_e state_q;
  cpass_e cpass_q;
  op_e    op_q;

  // config
  logic        motion_en_q;
  logic [23:0] timeout_q;
  logic signed [31:0] mount_x_q, mount_y_q, mount_z_q, base_h_q;
  logic [16:0] mount_yaw_q;

  // architectural state
  logic signed [31:0] pose_x_q, pose_y_q;
  logic [16:0] pose_yaw_q;
  logic [31:0] last_tick_q, cmd_time_q;
  logic        tick_seen_q, cmd_seen_q;
  logic signed [23:0] held_fwd_q, held_side_q, held_turn_q;

  // working registers
  logic signed [23:0] f_q, sd_q, tr_q;
  logic [poi_pkg::DT_W-1:0] dt_q;
  logic signed [35:0] vx_q, vy_q;
  logic signed [31:0] rx_q, ry_q;
  logic signed [PW-1:0] acc_q, prod_q;
  logic        neg_q;
  logic        cord_start_q;
  logic [31:0] cord_phase_q;
  poi_pkg::div_req_t div_req_q;

  logic        cord_done, div_done;
  logic signed [poi_pkg::CW-1:0] cs, cc;
  logic [poi_pkg::DIV_QB-1:0] quo;

  logic signed [35:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [PW-1:0] prod, diff, sum, rnd20_d, rnd20_s, rnd30_d, rnd30_s;
  logic signed [PW-1:0] mag;
  logic signed [31:0] delta;
  logic [31:0] dt_full, age;
  logic        step_ok, vel_ok, in_acc;
  logic signed [poi_pkg::CW-1:0] qz_r, qw_r;
  logic signed [15:0] qz_sat, qw_sat;
  logic [16:0] total_yaw;

  poi_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cord_start_q),
    .phase_i (cord_phase_q),
    .done_o  (cord_done),
    .sin_o   (cs),
    .cos_o   (cc)
  );

  poi_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .done_o (div_done),
    .quo_o  (quo)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (op_q)
      OP_FC:   begin mul_a = 36'(f_q);  mul_b = cc; end
      OP_SDS:  begin mul_a = 36'(sd_q); mul_b = cs; end
      OP_FS:   begin mul_a = 36'(f_q);  mul_b = cs; end
      OP_SDC:  begin mul_a = 36'(sd_q); mul_b = cc; end
      OP_VXDT: begin mul_a = vx_q; mul_b = $signed({14'b0, dt_q}); end
      OP_VYDT: begin mul_a = vy_q; mul_b = $signed({14'b0, dt_q}); end
      OP_TRDT: begin mul_a = 36'(tr_q); mul_b = $signed({14'b0, dt_q}); end
      OP_MXC:  begin mul_a = 36'(mount_x_q); mul_b = cc; end
      OP_MYS:  begin mul_a = 36'(mount_y_q); mul_b = cs; end
      OP_MXS:  begin mul_a = 36'(mount_x_q); mul_b = cs; end
      OP_MYC:  begin mul_a = 36'(mount_y_q); mul_b = cc; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    prod    = PW'(mul_a) * PW'(mul_b);
    diff    = acc_q - prod_q;
    sum     = acc_q + prod_q;
    rnd20_d = (diff + (PW'(1) <<< 19)) >>> 20;
    rnd20_s = (sum  + (PW'(1) <<< 19)) >>> 20;
    rnd30_d = (diff + (PW'(1) <<< 29)) >>> 30;
    rnd30_s = (sum  + (PW'(1) <<< 29)) >>> 30;
    mag     = prod_q[PW-1] ? -prod_q : prod_q;
    delta   = neg_q ? -$signed({5'b0, quo}) : $signed({5'b0, quo});

    dt_full = time_us_i - last_tick_q;
    age     = time_us_i - cmd_time_q;
    step_ok = motion_en_q && tick_seen_q && (dt_full != 32'd0) &&
              (dt_full <= 32'(poi_pkg::MAX_STEP_US));
    vel_ok  = cmd_seen_q && (age <= {8'b0, timeout_q});
    in_acc  = in_valid_i && in_ready_o;

    total_yaw = pose_yaw_q + mount_yaw_q;
    qz_r = (cs + 34'sd16384) >>> 15;
    qw_r = (cc + 34'sd16384) >>> 15;
    qz_sat = (qz_r > 34'sd32767) ? 16'sh7fff :
             (qz_r < -34'sd32768) ? 16'sh8000 : qz_r[15:0];
    qw_sat = (qw_r > 34'sd32767) ? 16'sh7fff :
             (qw_r < -34'sd32768) ? 16'sh8000 : qw_r[15:0];
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cpass_q      <= C_STEP;
      op_q         <= OP_FC;
      motion_en_q  <= 1'b0;
      timeout_q    <= 24'd500000;
      mount_x_q    <= 32'sd0;
      mount_y_q    <= 32'sd7864;
      mount_z_q    <= 32'sd22938;
      mount_yaw_q  <= 17'd0;
      base_h_q     <= 32'sd0;
      pose_x_q     <= '0;
      pose_y_q     <= '0;
      pose_yaw_q   <= '0;
      last_tick_q  <= '0;
      cmd_time_q   <= '0;
      tick_seen_q  <= 1'b0;
      cmd_seen_q   <= 1'b0;
      held_fwd_q   <= '0;
      held_side_q  <= '0;
      held_turn_q  <= '0;
      out_valid_o  <= 1'b0;
      cord_start_q <= 1'b0;
      div_req_q    <= '0;
    end else begin
      cord_start_q    <= 1'b0;
      div_req_q.start <= 1'b0;
      if (state_q == S_OUT && (!out_valid_o || out_ready_i)) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end

      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          poi_pkg::REG_MOTION_ENABLE: motion_en_q <= cfg_data_i[0];
          poi_pkg::REG_CMD_TIMEOUT:   timeout_q   <= cfg_data_i[23:0];
          poi_pkg::REG_MOUNT_X:       mount_x_q   <= cfg_data_i;
          poi_pkg::REG_MOUNT_Y:       mount_y_q   <= cfg_data_i;
          poi_pkg::REG_MOUNT_Z:       mount_z_q   <= cfg_data_i;
          poi_pkg::REG_MOUNT_YAW:     mount_yaw_q <= cfg_data_i[16:0];
          poi_pkg::REG_BASE_HEIGHT:   base_h_q    <= cfg_data_i;
          default: ;
        endcase
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (!action_i) begin
              held_fwd_q  <= vel_fwd_i;
              held_side_q <= vel_side_i;
              held_turn_q <= turn_rate_i;
              cmd_time_q  <= time_us_i;
              cmd_seen_q  <= 1'b1;
            end else begin
              f_q  <= vel_ok ? held_fwd_q  : 24'sd0;
              sd_q <= vel_ok ? held_side_q : 24'sd0;
              tr_q <= vel_ok ? held_turn_q : 24'sd0;
              dt_q <= dt_full[poi_pkg::DT_W-1:0];
              last_tick_q  <= time_us_i;
              tick_seen_q  <= 1'b1;
              cord_start_q <= 1'b1;
              cord_phase_q <= {pose_yaw_q[15:0], 16'b0};
              cpass_q      <= step_ok ? C_STEP : C_MOUNT;
              state_q      <= S_CORD;
            end
          end
        end
        S_CORD: begin
          if (cord_done) begin
            unique case (cpass_q)
              C_STEP:  begin op_q <= OP_FC;  state_q <= S_MUL; end
              C_MOUNT: begin op_q <= OP_MXC; state_q <= S_MUL; end
              default: state_q <= S_OUT;
            endcase
          end
        end
        S_MUL: begin
          prod_q  <= prod;
          state_q <= S_ACC;
        end
        S_ACC: begin
          state_q <= S_MUL;
          unique case (op_q) inside
            OP_FC, OP_FS, OP_MXC, OP_MXS: begin
              acc_q <= prod_q;
              op_q  <= op_e'(op_q + 4'd1);
            end
            OP_SDS: begin vx_q <= rnd20_d[35:0]; op_q <= OP_FS; end
            OP_SDC: begin vy_q <= rnd20_s[35:0]; op_q <= OP_VXDT; end
            OP_VXDT, OP_VYDT, OP_TRDT: begin
              // magnitude rounded half away from zero through the divider
              neg_q             <= prod_q[PW-1];
              div_req_q.start   <= 1'b1;
              div_req_q.pos_den <= (op_q != OP_TRDT);
              div_req_q.num     <= mag[poi_pkg::DIV_W-1:0] +
                                   ((op_q != OP_TRDT) ? (poi_pkg::DEN_POS >> 1)
                                                      : (poi_pkg::DEN_YAW >> 1));
              state_q           <= S_DIV;
            end
            OP_MYS: begin rx_q <= rnd30_d[31:0]; op_q <= OP_MXS; end
            OP_MYC: begin
              ry_q         <= rnd30_s[31:0];
              cord_start_q <= 1'b1;
              cord_phase_q <= {total_yaw, 15'b0};
              cpass_q      <= C_QUAT;
              state_q      <= S_CORD;
            end
            default: state_q <= S_IDLE;
          endcase
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_MUL;
            unique case (op_q)
              OP_VXDT: begin pose_x_q <= pose_x_q + delta; op_q <= OP_VYDT; end
              OP_VYDT: begin pose_y_q <= pose_y_q + delta; op_q <= OP_TRDT; end
              default: begin
                pose_yaw_q   <= pose_yaw_q + delta[16:0];
                cord_start_q <= 1'b1;
                cord_phase_q <= {pose_yaw_q[15:0] + delta[15:0], 16'b0};
                cpass_q      <= C_MOUNT;
                state_q      <= S_CORD;
              end
            endcase
          end
        end
        S_OUT: begin
          // payload only changes once the previous result has left
          if (!out_valid_o || out_ready_i) begin
            pos_x_o     <= pose_x_q + rx_q;
            pos_y_o     <= pose_y_q + ry_q;
            pos_z_o     <= base_h_q + mount_z_q;
            quat_z_o    <= qz_sat;
            quat_w_o    <= qw_sat;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_cord_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cord_done |-> state_q == S_CORD)
    else $error("cordic finished outside its wait state");

  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside its wait state");

  a_cmd_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !action_i) |=> !$rose(out_valid_o))
    else $error("command transaction produced a result");

  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && action_i) |=> !in_ready_o)
    else $error("tick transaction did not start the sequencer");

endmodule
